/* design/hrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_pkg
// Types and fixed codes shared by the request framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_in;
    } item_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  section;
        logic [5:0]  header_number;
        logic        is_length_value;
        logic [30:0] content_length;
        logic        request_done;
        logic [1:0]  error_code;
    } tag_t;

    localparam logic ACT_DATA    = 1'b0;
    localparam logic ACT_ABANDON = 1'b1;

    localparam logic [2:0] SEC_METHOD  = 3'd0;
    localparam logic [2:0] SEC_PATH    = 3'd1;
    localparam logic [2:0] SEC_VERSION = 3'd2;
    localparam logic [2:0] SEC_EXTRA   = 3'd3;
    localparam logic [2:0] SEC_NAME    = 3'd4;
    localparam logic [2:0] SEC_VALUE   = 3'd5;
    localparam logic [2:0] SEC_DELIM   = 3'd6;
    localparam logic [2:0] SEC_BODY    = 3'd7;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_NODIGITS = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;

    localparam logic [3:0] NAME_LEN = 4'd14;
    localparam logic [8*14-1:0] LEN_NAME = "Content-Length";

    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] c;
        c = 8'd0;
        if (pos < NAME_LEN)
            c = LEN_NAME[(4'd13 - pos) * 8 +: 8];
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

/* design/http_request_framer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_framer_top
// Tags each byte of an HTTP/1.1 request stream with the part it belongs to.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_ready/item): one transaction per received
// byte, or an abandon request that drops a partial request.
// Output channel (tag_valid/tag_ready/tag): exactly one transaction per
// input transaction, in order: the byte echoed with its section, header
// index, Content-Length value parsed so far, completion flag and error code.
// The tag of a taken byte is registered and offered in the next cycle. Unless
// stalled, throughput is one byte per cycle; all per-byte work is the parser
// state update between the state registers and the single result register.
// item_ready stays high while the result register is empty or being taken,
// so a stalled receiver holds one result and then stops the input channel.
// Reset empties the result register and puts the parser at the start of a
// request line. LENGTH_BITS sets the internal length width (content_length
// reports its low 31 bits); MAX_HEADERS caps the header index.
// ----------------------------------------------------------------------------
module http_request_framer_top #(
    parameter int MAX_HEADERS = 64,
    parameter int LENGTH_BITS = 31
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  hrf_pkg::item_t item,
    output logic           tag_valid,
    input  logic           tag_ready,
    output hrf_pkg::tag_t  tag
);

    localparam int LW = LENGTH_BITS + 4;
    localparam int HDR_CAP_I = (MAX_HEADERS - 1 < 63) ? MAX_HEADERS - 1 : 63;
    localparam logic [5:0] HDR_CAP = 6'(HDR_CAP_I);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LW-1:0] LIM_POS = {4'd0, LEN_MAX};
    localparam logic [LW-1:0] LIM_NEG = LIM_POS + LW'(1);

    localparam logic [1:0] PH_LINE = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [1:0] HP_NAME  = 2'd0;
    localparam logic [1:0] HP_SKIP  = 2'd1;
    localparam logic [1:0] HP_VALUE = 2'd2;

    localparam logic [1:0] DP_LEAD   = 2'd0;
    localparam logic [1:0] DP_SIGN   = 2'd1;
    localparam logic [1:0] DP_DIGITS = 2'd2;
    localparam logic [1:0] DP_END    = 2'd3;

    logic [1:0]             phase_reg, phase_next;
    logic [1:0]             token_reg, token_next;
    logic                   in_token_reg, in_token_next;
    logic                   crp_reg, crp_next;
    logic                   nonempty_reg, nonempty_next;
    logic [1:0]             hpart_reg, hpart_next;
    logic [3:0]             mpos_reg, mpos_next;
    logic                   matches_reg, matches_next;
    logic [LENGTH_BITS-1:0] lval_reg, lval_next;
    logic [1:0]             dphase_reg, dphase_next;
    logic                   neg_reg, neg_next;
    logic                   bad_reg, bad_next;
    logic [LENGTH_BITS-1:0] body_reg, body_next;
    logic [5:0]             hcount_reg, hcount_next;

    hrf_pkg::tag_t tag_reg, tag_next;
    logic          tag_valid_reg;
    logic          item_fire;
    logic          done_c;

    logic [7:0]             b;
    logic                   cr;
    logic                   dig;
    logic [LW-1:0]          prod;
    logic [LENGTH_BITS-1:0] eff;
    logic [63:0]            eff_ext;
    logic [2:0]             sect;
    logic [1:0]             err;
    logic                   islen;

    assign item_ready = !tag_valid_reg || tag_ready;
    assign item_fire  = item_valid && item_ready;
    assign tag_valid  = tag_valid_reg;
    assign tag        = tag_reg;

    assign b    = item.byte_in;
    assign cr   = (b == hrf_pkg::CH_CR);
    assign dig  = (b >= hrf_pkg::CH_ZERO) && (b <= hrf_pkg::CH_NINE);
    assign prod = {1'b0, lval_reg, 3'b000} + {3'b000, lval_reg, 1'b0}
                + LW'(b - hrf_pkg::CH_ZERO);

    always_comb
    begin
        phase_next    = phase_reg;
        token_next    = token_reg;
        in_token_next = in_token_reg;
        crp_next      = crp_reg;
        nonempty_next = nonempty_reg;
        hpart_next    = hpart_reg;
        mpos_next     = mpos_reg;
        matches_next  = matches_reg;
        lval_next     = lval_reg;
        dphase_next   = dphase_reg;
        neg_next      = neg_reg;
        bad_next      = bad_reg;
        body_next     = body_reg;
        hcount_next   = hcount_reg;
        sect          = hrf_pkg::SEC_DELIM;
        err           = hrf_pkg::ERR_NONE;
        islen         = 1'b0;
        done_c        = 1'b0;

        if (phase_reg == PH_BODY)
        begin
            sect = hrf_pkg::SEC_BODY;
            if (body_reg != '0)
                body_next = body_reg - 1'b1;
            if (body_next == '0)
                done_c = 1'b1;
        end
        else if (b == hrf_pkg::CH_LF && crp_reg)
        begin
            if (phase_reg == PH_LINE)
                phase_next = PH_HDR;
            else if (!nonempty_reg)
            begin
                if (!neg_reg && lval_reg != '0)
                begin
                    phase_next = PH_BODY;
                    body_next  = lval_reg;
                end
                else
                    done_c = 1'b1;
            end
            else
            begin
                if (matches_reg && hpart_reg != HP_NAME)
                begin
                    if (bad_reg || dphase_reg == DP_LEAD || dphase_reg == DP_SIGN)
                    begin
                        err       = hrf_pkg::ERR_NODIGITS;
                        lval_next = '0;
                    end
                    if (neg_reg)
                        lval_next = '0;
                    neg_next = 1'b0;
                end
                if (hcount_reg < HDR_CAP)
                    hcount_next = hcount_reg + 6'd1;
            end
            in_token_next = 1'b0;
            crp_next      = 1'b0;
            nonempty_next = 1'b0;
            hpart_next    = HP_NAME;
            mpos_next     = 4'd0;
            matches_next  = 1'b1;
        end
        else if (phase_reg == PH_LINE)
        begin
            crp_next = cr;
            if (hrf_pkg::is_ws(b))
                in_token_next = 1'b0;
            else
            begin
                if (!in_token_reg)
                begin
                    if (nonempty_reg && token_reg < 2'd3)
                        token_next = token_reg + 2'd1;
                    nonempty_next = 1'b1;
                    in_token_next = 1'b1;
                end
                sect = {1'b0, token_next};
            end
        end
        else
        begin
            crp_next = cr;
            if (crp_reg || !cr)
                nonempty_next = 1'b1;
            if (hpart_reg == HP_NAME)
            begin
                if (b == hrf_pkg::CH_COLON)
                begin
                    hpart_next   = HP_SKIP;
                    matches_next = matches_reg && (mpos_reg == hrf_pkg::NAME_LEN);
                    if (matches_next)
                    begin
                        lval_next   = '0;
                        dphase_next = DP_LEAD;
                        neg_next    = 1'b0;
                        bad_next    = 1'b0;
                    end
                end
                else
                begin
                    if (matches_reg && mpos_reg < hrf_pkg::NAME_LEN
                        && b == hrf_pkg::name_char(mpos_reg))
                        mpos_next = mpos_reg + 4'd1;
                    else
                        matches_next = 1'b0;
                    if (!cr)
                        sect = hrf_pkg::SEC_NAME;
                end
            end
            else if (hpart_reg == HP_SKIP)
                hpart_next = HP_VALUE;
            else
            begin
                if (!cr)
                begin
                    sect  = hrf_pkg::SEC_VALUE;
                    islen = matches_reg;
                end
                if (matches_reg && !bad_reg && dphase_reg != DP_END)
                begin
                    if (!dig)
                    begin
                        if (dphase_reg == DP_LEAD && hrf_pkg::is_ws(b))
                            dphase_next = DP_LEAD;
                        else if (dphase_reg == DP_LEAD
                                 && (b == hrf_pkg::CH_PLUS || b == hrf_pkg::CH_MINUS))
                        begin
                            neg_next    = (b == hrf_pkg::CH_MINUS);
                            dphase_next = DP_SIGN;
                        end
                        else if (dphase_reg == DP_DIGITS)
                            dphase_next = DP_END;
                        else
                            bad_next = 1'b1;
                    end
                    else
                    begin
                        dphase_next = DP_DIGITS;
                        if (prod > (neg_reg ? LIM_NEG : LIM_POS))
                        begin
                            lval_next = LEN_MAX;
                            err       = hrf_pkg::ERR_OVERFLOW;
                        end
                        else if (prod > LIM_POS)
                            lval_next = LEN_MAX;
                        else
                            lval_next = prod[LENGTH_BITS-1:0];
                    end
                end
            end
        end

        eff     = neg_next ? '0 : lval_next;
        eff_ext = 64'(eff);

        tag_next.byte_out        = b;
        tag_next.section         = sect;
        tag_next.header_number   = hcount_reg;
        tag_next.is_length_value = islen;
        tag_next.content_length  = eff_ext[30:0];
        tag_next.request_done    = done_c;
        tag_next.error_code      = err;

        if (item.action == hrf_pkg::ACT_ABANDON || done_c)
        begin
            phase_next    = PH_LINE;
            token_next    = 2'd0;
            in_token_next = 1'b0;
            crp_next      = 1'b0;
            nonempty_next = 1'b0;
            hpart_next    = HP_NAME;
            mpos_next     = 4'd0;
            matches_next  = 1'b1;
            lval_next     = '0;
            dphase_next   = DP_LEAD;
            neg_next      = 1'b0;
            bad_next      = 1'b0;
            body_next     = '0;
            hcount_next   = 6'd0;
        end
        if (item.action == hrf_pkg::ACT_ABANDON)
        begin
            tag_next         = '0;
            tag_next.section = hrf_pkg::SEC_DELIM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE;
            token_reg     <= 2'd0;
            in_token_reg  <= 1'b0;
            crp_reg       <= 1'b0;
            nonempty_reg  <= 1'b0;
            hpart_reg     <= HP_NAME;
            mpos_reg      <= 4'd0;
            matches_reg   <= 1'b1;
            lval_reg      <= '0;
            dphase_reg    <= DP_LEAD;
            neg_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            body_reg      <= '0;
            hcount_reg    <= 6'd0;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_fire)
            begin
                phase_reg    <= phase_next;
                token_reg    <= token_next;
                in_token_reg <= in_token_next;
                crp_reg      <= crp_next;
                nonempty_reg <= nonempty_next;
                hpart_reg    <= hpart_next;
                mpos_reg     <= mpos_next;
                matches_reg  <= matches_next;
                lval_reg     <= lval_next;
                dphase_reg   <= dphase_next;
                neg_reg      <= neg_next;
                bad_reg      <= bad_next;
                body_reg     <= body_next;
                hcount_reg   <= hcount_next;
            end
            if (item_fire)
                tag_valid_reg <= 1'b1;
            else if (tag_ready)
                tag_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
            tag_reg <= tag_next;
    end

    // body phase is only entered with a non-zero count and left when it runs out
    a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> body_reg != '0)
        else $error("body phase with zero bytes left");

    a_abandon_tag: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.action == hrf_pkg::ACT_ABANDON |=>
            tag_valid && tag.section == hrf_pkg::SEC_DELIM
            && tag.header_number == 6'd0 && !tag.request_done)
        else $error("abandon result malformed");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.action == hrf_pkg::ACT_DATA && done_c |=>
            phase_reg == PH_LINE && hcount_reg == 6'd0
            && lval_reg == '0 && tag.request_done)
        else $error("request state not cleared after completion");

    a_hcount_cap: assert property (@(posedge clk) disable iff (!rst_n)
        hcount_reg <= HDR_CAP)
        else $error("header index beyond cap");

    a_mpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        mpos_reg <= hrf_pkg::NAME_LEN && (mpos_reg == 4'd0 || phase_reg == PH_HDR))
        else $error("name match position out of range");

endmodule
